@@ rtl/interval_color_segment_tree_defines.svh @@
// Assertion macros for the interval color segment tree RTL.
`ifndef INTERVAL_COLOR_SEGMENT_TREE_DEFINES_SVH
`define INTERVAL_COLOR_SEGMENT_TREE_DEFINES_SVH
`ifndef SYNTH
`define ICST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ICST_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ICST_ASSERT(lbl, clk, rstn, prop)
`define ICST_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ rtl/icst_pkg.sv @@
`default_nettype none
package icst_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_FETCH, ST_EVAL, ST_PUSH_L, ST_PUSH_R,
    ST_STEP, ST_PULL_RL, ST_PULL_RR, ST_PULL_WR, ST_DONE
  } state_e;

  typedef enum logic [1:0] {PH_LEFT, PH_RIGHT, PH_DONE} phase_e;
  typedef enum logic [1:0] {RD_TOP, RD_LEFT, RD_RIGHT} rd_sel_e;
  typedef enum logic [2:0] {WR_CLEAR, WR_PAINT, WR_LEFT, WR_RIGHT, WR_PULL} wr_sel_e;
  typedef enum logic {ACC_NODE, ACC_PEND} acc_sel_e;

  localparam logic ACT_PAINT = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic     clr_en;
    logic     load_en;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     acc_en;
    acc_sel_e acc_sel;
    logic     phase_en;
    phase_e   phase_val;
    logic     push_en;
    logic     push_right;
    logic     pop_en;
    logic     hold_en;
    logic     out_en;
  } dp_cmd_t;

  typedef struct packed {
    logic   clr_last;
    logic   is_query;
    logic   skip;
    logic   covered;
    logic   pend_nz;
    logic   go_left;
    logic   go_right;
    phase_e phase;
    logic   last_frame;
    logic   out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/icst_ctrl.sv @@
`default_nettype none
module icst_ctrl
  import icst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CLEAR;
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        if (stat_i.skip) state_d = stat_i.is_query ? ST_DONE : ST_IDLE;
        else state_d = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_TOP;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat_i.is_query) begin
          if (stat_i.covered || stat_i.pend_nz) begin
            // a pending node is one solid color over its whole span
            cmd_o.acc_en  = 1'b1;
            cmd_o.acc_sel = stat_i.covered ? ACC_NODE : ACC_PEND;
            cmd_o.pop_en  = 1'b1;
            state_d       = stat_i.last_frame ? ST_DONE : ST_STEP;
          end else begin
            cmd_o.phase_en  = 1'b1;
            cmd_o.phase_val = PH_LEFT;
            state_d         = ST_STEP;
          end
        end else if (stat_i.covered) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_PAINT;
          cmd_o.pop_en = 1'b1;
          state_d      = stat_i.last_frame ? ST_IDLE : ST_STEP;
        end else if (stat_i.pend_nz) begin
          state_d = ST_PUSH_L;
        end else begin
          cmd_o.phase_en  = 1'b1;
          cmd_o.phase_val = PH_LEFT;
          state_d         = ST_STEP;
        end
      end
      ST_PUSH_L: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LEFT;
        state_d      = ST_PUSH_R;
      end
      ST_PUSH_R: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_RIGHT;
        cmd_o.phase_en  = 1'b1;
        cmd_o.phase_val = PH_LEFT;
        state_d         = ST_STEP;
      end
      ST_STEP: begin
        case (stat_i.phase)
          PH_LEFT: begin
            cmd_o.phase_en  = 1'b1;
            cmd_o.phase_val = PH_RIGHT;
            if (stat_i.go_left) begin
              cmd_o.push_en = 1'b1;
              state_d       = ST_FETCH;
            end
          end
          PH_RIGHT: begin
            cmd_o.phase_en  = 1'b1;
            cmd_o.phase_val = PH_DONE;
            if (stat_i.go_right) begin
              cmd_o.push_en    = 1'b1;
              cmd_o.push_right = 1'b1;
              state_d          = ST_FETCH;
            end
          end
          default: begin
            if (stat_i.is_query) begin
              cmd_o.pop_en = 1'b1;
              state_d      = stat_i.last_frame ? ST_DONE : ST_STEP;
            end else begin
              state_d = ST_PULL_RL;
            end
          end
        endcase
      end
      ST_PULL_RL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LEFT;
        state_d      = ST_PULL_RR;
      end
      ST_PULL_RR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_RIGHT;
        cmd_o.hold_en = 1'b1;
        state_d       = ST_PULL_WR;
      end
      ST_PULL_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_PULL;
        cmd_o.pop_en = 1'b1;
        state_d      = stat_i.last_frame ? ST_IDLE : ST_STEP;
      end
      ST_DONE: begin
        // hold until the result slot frees up
        if (stat_i.out_free) begin
          cmd_o.out_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/icst_dp.sv @@
`include "interval_color_segment_tree_defines.svh"
`default_nettype none
module icst_dp
  import icst_pkg::*;
#(
  parameter int CELLS      = 8192,
  parameter int COLOR_BITS = 13,
  parameter int POS_BITS   = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  action_i,
  input  logic [POS_BITS-1:0]   range_low_i,
  input  logic [POS_BITS-1:0]   range_high_i,
  input  logic [COLOR_BITS-1:0] paint_color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [POS_BITS-1:0]   run_count_o,
  output logic [COLOR_BITS-1:0] left_color_o,
  output logic [COLOR_BITS-1:0] right_color_o
);

  localparam int LEVELS    = $clog2(CELLS);
  localparam int NODE_BITS = LEVELS + 1;
  localparam int NODES     = 2 ** NODE_BITS;
  localparam int STK_DEPTH = LEVELS + 1;
  localparam int STK_BITS  = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
  localparam int CB        = COLOR_BITS;
  localparam int SPAN_W    = POS_BITS + 2 * CB;
  localparam int NODE_W    = SPAN_W + CB;

  // span layout: {runs, left color, right color}
  function automatic logic [SPAN_W-1:0] join_span(logic [SPAN_W-1:0] a,
                                                  logic [SPAN_W-1:0] b);
    logic [POS_BITS:0] sum;
    sum = {1'b0, a[SPAN_W-1 -: POS_BITS]} + {1'b0, b[SPAN_W-1 -: POS_BITS]};
    if (a[CB-1:0] == b[2*CB-1:CB] && a[CB-1:0] != '0 && sum != '0)
      sum = sum - (POS_BITS + 1)'(1);
    return {sum[POS_BITS-1:0], a[2*CB-1:CB], b[CB-1:0]};
  endfunction

  logic                  act_q;
  logic [POS_BITS-1:0]   lo_q, hi_q;
  logic [CB-1:0]         color_q;
  logic [NODE_BITS-1:0]  stk_node_q [STK_DEPTH];
  logic [POS_BITS-1:0]   stk_s_q    [STK_DEPTH];
  logic [POS_BITS-1:0]   stk_e_q    [STK_DEPTH];
  phase_e                stk_ph_q   [STK_DEPTH];
  logic [STK_BITS-1:0]   tos_q;
  logic [NODE_W-1:0]     mem [NODES];
  logic [NODE_W-1:0]     rdata_q;
  logic [SPAN_W-1:0]     hold_q;
  logic [SPAN_W-1:0]     acc_q, acc_d, acc_x;
  logic                  acc_vld_q;
  logic [NODE_BITS-1:0]  clr_q;
  logic                  out_valid_q;
  logic [SPAN_W-1:0]     out_q;

  logic [STK_BITS-1:0]   tos_nxt;
  logic [NODE_BITS-1:0]  top_node, left_node, right_node, raddr, waddr;
  logic [POS_BITS-1:0]   top_s, top_e, mid, lo_c, hi_c;
  logic [POS_BITS:0]     mid_sum;
  logic [CB-1:0]         rd_pend;
  logic [NODE_W-1:0]     wdata;

  assign tos_nxt    = tos_q + STK_BITS'(1);
  assign top_node   = stk_node_q[tos_q];
  assign top_s      = stk_s_q[tos_q];
  assign top_e      = stk_e_q[tos_q];
  assign left_node  = {top_node[NODE_BITS-2:0], 1'b0};
  assign right_node = {top_node[NODE_BITS-2:0], 1'b1};
  assign mid_sum    = {1'b0, top_s} + {1'b0, top_e};
  assign mid        = mid_sum[POS_BITS:1];
  assign rd_pend    = rdata_q[CB-1:0];

  assign lo_c = (range_low_i == '0) ? POS_BITS'(1) : range_low_i;
  assign hi_c = (range_high_i > POS_BITS'(CELLS)) ? POS_BITS'(CELLS) : range_high_i;

  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = &clr_q;
    stat_o.is_query   = (act_q == ACT_QUERY);
    stat_o.skip       = (lo_q > hi_q) || (act_q == ACT_PAINT && color_q == '0);
    stat_o.covered    = (lo_q <= top_s) && (top_e <= hi_q);
    stat_o.pend_nz    = (rd_pend != '0);
    stat_o.go_left    = (lo_q <= mid);
    stat_o.go_right   = (mid < hi_q);
    stat_o.phase      = stk_ph_q[tos_q];
    stat_o.last_frame = (tos_q == '0);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_LEFT:  raddr = left_node;
      RD_RIGHT: raddr = right_node;
      default:  raddr = top_node;
    endcase
  end

  always_comb begin
    waddr = top_node;
    wdata = '0;
    case (cmd_i.wr_sel)
      WR_CLEAR: waddr = clr_q;
      WR_PAINT: wdata = {POS_BITS'(1), color_q, color_q, color_q};
      WR_LEFT: begin
        waddr = left_node;
        wdata = {POS_BITS'(1), rd_pend, rd_pend, rd_pend};
      end
      WR_RIGHT: begin
        waddr = right_node;
        wdata = {POS_BITS'(1), rd_pend, rd_pend, rd_pend};
      end
      WR_PULL: wdata = {join_span(hold_q, rdata_q[NODE_W-1:CB]), {CB{1'b0}}};
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  always_comb begin
    if (cmd_i.acc_sel == ACC_NODE) acc_x = rdata_q[NODE_W-1:CB];
    else acc_x = {POS_BITS'(1), rd_pend, rd_pend};
    acc_d = acc_vld_q ? join_span(acc_q, acc_x) : acc_x;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      act_q         <= action_i;
      lo_q          <= lo_c;
      hi_q          <= hi_c;
      color_q       <= paint_color_i;
      stk_node_q[0] <= NODE_BITS'(1);
      stk_s_q[0]    <= POS_BITS'(1);
      stk_e_q[0]    <= POS_BITS'(CELLS);
      stk_ph_q[0]   <= PH_LEFT;
    end else begin
      if (cmd_i.phase_en) stk_ph_q[tos_q] <= cmd_i.phase_val;
      if (cmd_i.push_en) begin
        stk_node_q[tos_nxt] <= cmd_i.push_right ? right_node : left_node;
        stk_s_q[tos_nxt]    <= cmd_i.push_right ? mid + POS_BITS'(1) : top_s;
        stk_e_q[tos_nxt]    <= cmd_i.push_right ? top_e : mid;
        stk_ph_q[tos_nxt]   <= PH_LEFT;
      end
    end
    if (cmd_i.hold_en) hold_q <= rdata_q[NODE_W-1:CB];
    if (cmd_i.acc_en) acc_q <= acc_d;
    if (cmd_i.out_en) out_q <= acc_vld_q ? acc_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tos_q       <= '0;
      acc_vld_q   <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) clr_q <= clr_q + NODE_BITS'(1);
      if (cmd_i.load_en) tos_q <= '0;
      else if (cmd_i.push_en) tos_q <= tos_nxt;
      else if (cmd_i.pop_en && tos_q != '0) tos_q <= tos_q - STK_BITS'(1);
      if (cmd_i.load_en) acc_vld_q <= 1'b0;
      else if (cmd_i.acc_en) acc_vld_q <= 1'b1;
      if (cmd_i.out_en) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign run_count_o   = out_q[SPAN_W-1 -: POS_BITS];
  assign left_color_o  = out_q[2*CB-1:CB];
  assign right_color_o = out_q[CB-1:0];

  `ICST_NEVER(a_rd_wr_clash, clk_i, rst_ni, cmd_i.rd_en && cmd_i.wr_en)
  `ICST_NEVER(a_stack_over, clk_i, rst_ni, cmd_i.push_en && tos_q == STK_BITS'(STK_DEPTH - 1))
  `ICST_ASSERT(a_out_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.out_en))
  `ICST_ASSERT(a_out_free, clk_i, rst_ni, cmd_i.out_en |-> (!out_valid_q || !out_stall_i))

endmodule
`default_nettype wire

@@ rtl/interval_color_segment_tree.sv @@
// Channel  Handshake               Fields
// in       in_valid_i/in_stall_o   action_i, range_low_i, range_high_i, paint_color_i
// out      out_valid_o/out_stall_i run_count_o, left_color_o, right_color_o
//
// After reset the node memory is swept to zero, one node a cycle, over all
// 2*2**clog2(CELLS) nodes (16384 at the default size); no beat is taken then.
// A beat walks the tree from the root; a query joins the spans of covered or pending
// nodes, a paint writes covered nodes, pushes pending colors down, pulls spans up.
// A query then waits for its result slot and holds there while the last result stalls.
// One beat is in work at a time; the next input beat is taken while a result waits.
`default_nettype none
module interval_color_segment_tree
  import icst_pkg::*;
#(
  parameter int CELLS      = 8192,
  parameter int COLOR_BITS = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [$clog2(CELLS+1)-1:0]    range_low_i,
  input  logic [$clog2(CELLS+1)-1:0]    range_high_i,
  input  logic [COLOR_BITS-1:0]         paint_color_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [$clog2(CELLS+1)-1:0]    run_count_o,
  output logic [COLOR_BITS-1:0]         left_color_o,
  output logic [COLOR_BITS-1:0]         right_color_o
);

  localparam int POS_BITS = $clog2(CELLS + 1);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  icst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  icst_dp #(
    .CELLS      (CELLS),
    .COLOR_BITS (COLOR_BITS),
    .POS_BITS   (POS_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .paint_color_i (paint_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .run_count_o   (run_count_o),
    .left_color_o  (left_color_o),
    .right_color_o (right_color_o)
  );

endmodule
`default_nettype wire
